@@ rtl/qte_pkg.sv @@
// qte_pkg: shared types, widths and coefficient scale table for the quintic
// trajectory evaluator. No dependencies; imported by every rtl module.
`default_nettype none

package qte_pkg;

  localparam int NUM_AXES  = 3;
  localparam int FRAC_BITS = 16;
  localparam int COEFS     = 6;

  localparam int DATA_W  = 32;
  localparam int TIME_W  = 24;
  localparam int SLOT_W  = 3;
  localparam int AXIS_W  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int SCALE_W = 5;

  // product of a signed word and the unsigned time, plus room for rounding
  localparam int PROD_W = DATA_W + TIME_W + 1;
  localparam int K_W    = DATA_W + SCALE_W + 1;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic [SLOT_W-1:0] TOP_POWER = SLOT_W'(COEFS - 1);
  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    POLY_POS,
    POLY_VEL,
    POLY_ACC
  } poly_t;

  typedef struct packed {
    logic                     mode;
    logic [1:0]               axis_select;
    logic [SLOT_W-1:0]        coef_slot;
    logic signed [DATA_W-1:0] coef_word;
    logic [TIME_W-1:0]        elapsed_time;
  } request_t;

  typedef struct packed {
    logic [1:0]               axis_id;
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] velocity;
    logic signed [DATA_W-1:0] acceleration;
    logic                     last_axis;
  } result_t;

  // derivative factor applied to the coefficient of a given power
  function automatic logic [SCALE_W-1:0] scale_of(poly_t poly, logic [SLOT_W-1:0] power);
    logic [SCALE_W-1:0] s;
    s = '0;
    case (poly)
      POLY_POS: s = SCALE_W'(1);
      POLY_VEL: s = SCALE_W'(power);
      POLY_ACC: begin
        case (power)
          3'd2:    s = SCALE_W'(2);
          3'd3:    s = SCALE_W'(6);
          3'd4:    s = SCALE_W'(12);
          3'd5:    s = SCALE_W'(20);
          default: s = '0;
        endcase
      end
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/quintic_trajectory_evaluator.sv @@
// quintic_trajectory_evaluator: coefficient store, step sequencer and result
// registers around one qte_horner_unit. Uses qte_pkg and qte_horner_unit.
`default_nettype none

// A load request (mode 0) writes one coefficient; busy never rises. An
// evaluate request (mode 1) keeps busy high up to and including the z result:
// every Horner step passes through a multiply state and an add state on
// the single shared multiply and accumulate unit (multiply, then round,
// add and saturate), an axis needs 6 + 5 + 4 = 15 steps for position,
// velocity and acceleration, and an output state presents its result; the
// next request is taken on the cycle after the z result.
// Each result is shown for one cycle with result_valid high; there is no way
// to hold it off, so the receiver must take it in that cycle.
module quintic_trajectory_evaluator import qte_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire request_t request,
  output logic          busy,
  output logic          result_valid,
  output result_t       result
);

  logic signed [DATA_W-1:0] coef_store [NUM_AXES][COEFS];

  state_t                   state, state_next;
  poly_t                    poly, poly_next;
  logic [AXIS_W-1:0]        axis, axis_next;
  logic [SLOT_W-1:0]        power, power_next;
  logic signed [DATA_W-1:0] acc, acc_next;
  logic [TIME_W-1:0]        t_reg, t_next;
  logic signed [DATA_W-1:0] res_pos, res_vel, res_acc;

  logic                     accept;
  logic                     load_en;
  logic                     mul_en;
  logic                     poly_done;
  logic signed [DATA_W-1:0] step_value;

  assign accept    = start && !busy;
  assign load_en   = accept && (request.mode == MODE_LOAD)
                     && (32'(request.axis_select) < NUM_AXES)
                     && (32'(request.coef_slot) < COEFS);
  assign poly_done = (state == S_ADD) && (power == SLOT_W'(poly));

  qte_horner_unit u_horner (
    .clk        (clk),
    .mul_en     (mul_en),
    .acc_in     (acc),
    .time_in    (t_reg),
    .coef       (coef_store[axis][power]),
    .scale      (scale_of(poly, power)),
    .step_value (step_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      poly  <= POLY_POS;
      axis  <= '0;
      power <= TOP_POWER;
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int c = 0; c < COEFS; c++) begin
          coef_store[a][c] <= '0;
        end
      end
    end else begin
      state <= state_next;
      poly  <= poly_next;
      axis  <= axis_next;
      power <= power_next;
      if (load_en) begin
        coef_store[request.axis_select[AXIS_W-1:0]][request.coef_slot] <= request.coef_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc   <= acc_next;
    t_reg <= t_next;
    if (poly_done) begin
      case (poly)
        POLY_POS: res_pos <= step_value;
        POLY_VEL: res_vel <= step_value;
        default:  res_acc <= step_value;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    poly_next  = poly;
    axis_next  = axis;
    power_next = power;
    acc_next   = acc;
    t_next     = t_reg;
    mul_en     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && (request.mode == MODE_EVAL)) begin
          t_next     = request.elapsed_time;
          axis_next  = '0;
          poly_next  = POLY_POS;
          power_next = TOP_POWER;
          acc_next   = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        mul_en     = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        if (poly_done) begin
          acc_next   = '0;
          power_next = TOP_POWER;
          if (poly == POLY_ACC) begin
            state_next = S_OUT;
          end else begin
            poly_next  = poly_t'(poly + 2'd1);
            state_next = S_MUL;
          end
        end else begin
          acc_next   = step_value;
          power_next = power - SLOT_W'(1);
          state_next = S_MUL;
        end
      end
      S_OUT: begin
        if (axis == LAST_AXIS) begin
          state_next = S_IDLE;
        end else begin
          axis_next  = axis + AXIS_W'(1);
          poly_next  = POLY_POS;
          power_next = TOP_POWER;
          state_next = S_MUL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy                = (state != S_IDLE);
  assign result_valid        = (state == S_OUT);
  assign result.axis_id      = 2'(axis);
  assign result.position     = res_pos;
  assign result.velocity     = res_vel;
  assign result.acceleration = res_acc;
  assign result.last_axis    = (axis == LAST_AXIS);

  // a result only appears inside an evaluate run
  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result strobe outside a run");

  // a strobe lasts exactly one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held longer than one cycle");

  // the z result ends the run
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_axis) |=> !busy)
    else $error("still busy after the last result");

  // an evaluate request starts a run, a load request does not
  a_eval_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.mode == MODE_EVAL)) |=> busy)
    else $error("evaluate request did not start a run");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.mode == MODE_LOAD)) |=> !busy)
    else $error("load request left the block busy");

endmodule

`default_nettype wire

@@ rtl/qte_horner_unit.sv @@
// qte_horner_unit: shared multiply / round / accumulate / saturate unit for
// one Horner step, product registered between the two halves. Uses qte_pkg.
`default_nettype none

module qte_horner_unit import qte_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     mul_en,
  input  wire logic signed [DATA_W-1:0] acc_in,
  input  wire logic [TIME_W-1:0]        time_in,
  input  wire logic signed [DATA_W-1:0] coef,
  input  wire logic [SCALE_W-1:0]       scale,
  output logic signed [DATA_W-1:0]      step_value
);

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_MAX    = SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_MIN    = -SAT_MAX - SUM_W'(1);

  logic signed [PROD_W-1:0] prod;
  logic signed [K_W-1:0]    k_scaled;
  logic signed [SUM_W-1:0]  rounded;
  logic signed [SUM_W-1:0]  sum;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod     <= PROD_W'(acc_in) * PROD_W'($signed({1'b0, time_in}));
      k_scaled <= K_W'(coef) * K_W'($signed({1'b0, scale}));
    end
  end

  // arithmetic shift gives floor, so this rounds half toward plus infinity
  always_comb begin
    rounded = (SUM_W'(prod) + ROUND_HALF) >>> FRAC_BITS;
    sum     = rounded + SUM_W'(k_scaled);
    if (sum > SAT_MAX) begin
      step_value = SAT_MAX[DATA_W-1:0];
    end else if (sum < SAT_MIN) begin
      step_value = SAT_MIN[DATA_W-1:0];
    end else begin
      step_value = sum[DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_quintic_trajectory_evaluator.sv @@
// Self-checking testbench for quintic_trajectory_evaluator: coefficient loads
// and evaluate requests, with a fixed point Horner predictor.
// Depends on qte_pkg and the rtl top level only.
module tb_quintic_trajectory_evaluator;
  import qte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // slowest run: about 165 requests, all evaluations run to their z result
  // plus short sender gaps, stays well under CYCLE_LIMIT
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 100;
  localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SAT_LO = -64'sh0000_0000_8000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  request_t request = '0;
  logic busy;
  logic result_valid;
  result_t result;

  quintic_trajectory_evaluator dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .result_valid(result_valid),
    .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic signed [DATA_W-1:0] coef_table [NUM_AXES*COEFS];
  request_t request_backlog [$];
  result_t due_samples [$];
  int planned = 0;
  int accepted = 0;
  int loads_sent = 0;
  int evals_sent = 0;
  int samples_checked = 0;
  int errors = 0;
  int cycles = 0;

  // horner over scaled coefficients, highest power first, saturating each step
  function automatic logic signed [DATA_W-1:0] eval_poly(int axis, poly_t poly, longint t);
    longint acc;
    longint k;
    int p;
    int d;
    int factor;
    d = int'(poly);
    acc = 0;
    for (p = COEFS - 1; p >= d; p--) begin
      factor = (d == 0) ? 1 : (d == 1) ? p : p * (p - 1);
      k = longint'(coef_table[axis*COEFS+p]) * factor;
      acc = ((acc * t + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS) + k;
      if (acc > SAT_HI) begin
        acc = SAT_HI;
      end else if (acc < SAT_LO) begin
        acc = SAT_LO;
      end
    end
    return acc[DATA_W-1:0];
  endfunction

  function automatic void apply_request(request_t r);
    result_t s;
    longint t;
    int a;
    if (r.mode == MODE_LOAD) begin
      loads_sent++;
      if (r.axis_select < NUM_AXES && r.coef_slot < COEFS)
        coef_table[r.axis_select*COEFS+r.coef_slot] = r.coef_word;
    end else begin
      evals_sent++;
      t = longint'(r.elapsed_time);
      for (a = 0; a < NUM_AXES; a++) begin
        s.axis_id = 2'(a);
        s.position = eval_poly(a, POLY_POS, t);
        s.velocity = eval_poly(a, POLY_VEL, t);
        s.acceleration = eval_poly(a, POLY_ACC, t);
        s.last_axis = (a == NUM_AXES - 1);
        due_samples.push_back(s);
      end
    end
  endfunction

  function automatic request_t load_req(int axis, int slot, logic [DATA_W-1:0] word);
    request_t r;
    r.mode = MODE_LOAD;
    r.axis_select = 2'(axis);
    r.coef_slot = SLOT_W'(slot);
    r.coef_word = word;
    r.elapsed_time = TIME_W'($urandom);
    return r;
  endfunction

  function automatic request_t eval_req(logic [TIME_W-1:0] t);
    request_t r;
    {r.axis_select, r.coef_slot} = 5'($urandom);
    r.coef_word = $urandom;
    r.mode = MODE_EVAL;
    r.elapsed_time = t;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] random_coef();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return $urandom_range(0, 2**18) - 2**17;
    if (r < 80) return $urandom_range(0, 2**21) - 2**20;
    return $urandom;
  endfunction

  function automatic logic [TIME_W-1:0] random_time();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return TIME_W'($urandom_range(0, 3 << FRAC_BITS));
    if (r < 85) return TIME_W'($urandom);
    case ($urandom_range(2))
      0: return '0;
      1: return '1;
      default: return TIME_W'(1 << FRAC_BITS);
    endcase
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s expected %h got %h", name, want, got);
      errors++;
    end
  endfunction

  // driver: one nonblocking update of start and request per edge
  always @(posedge clk) begin
    request_t nxt_req;
    logic nxt_start;
    logic [63:0] noise;
    int idle_pct;
    nxt_req = request;
    nxt_start = start;
    if (rst) begin
      nxt_start = 1'b0;
    end else begin
      if (start && !busy) begin
        apply_request(request);
        accepted++;
        nxt_start = 1'b0;
      end
      // phases: none, sender idle, receiver phase (results cannot be held
      // off, so no idling), both
      case ((accepted * 4) / planned)
        1: idle_pct = 49;
        3: idle_pct = 34;
        default: idle_pct = 0;
      endcase
      if (!nxt_start) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt_req = request_backlog.pop_front();
          nxt_start = 1'b1;
        end else begin
          noise = {$urandom, $urandom};
          nxt_req = noise[$bits(request_t)-1:0];
        end
      end
    end
    start <= nxt_start;
    request <= nxt_req;
  end

  // monitor: every strobed result is taken and compared with the oldest one due
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (due_samples.size() == 0) begin
        $error("result for axis %0d with no evaluation outstanding", result.axis_id);
        errors++;
      end else begin
        want = due_samples.pop_front();
        check_field("axis_id", DATA_W'(want.axis_id), DATA_W'(result.axis_id));
        check_field("position", want.position, result.position);
        check_field("velocity", want.velocity, result.velocity);
        check_field("acceleration", want.acceleration, result.acceleration);
        check_field("last_axis", DATA_W'(want.last_axis), DATA_W'(result.last_axis));
        samples_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               due_samples.size());
      $display("FAIL quintic_trajectory_evaluator");
      $finish;
    end
  end

  initial begin
    int i;
    int n;
    for (i = 0; i < NUM_AXES * COEFS; i++) coef_table[i] = '0;

    // all-zero store straight after reset
    request_backlog.push_back(eval_req('0));
    request_backlog.push_back(eval_req('1));
    // extremes: constant and top coefficient of x at the two rails, scaled derivatives overflow
    request_backlog.push_back(load_req(0, 0, 32'h7FFF_FFFF));
    request_backlog.push_back(load_req(0, 5, 32'h8000_0000));
    request_backlog.push_back(load_req(1, 5, 32'h0001_0000));
    request_backlog.push_back(load_req(1, 4, -(3 << FRAC_BITS)));
    request_backlog.push_back(load_req(1, 2, 32'h0001_2345));
    request_backlog.push_back(load_req(2, 3, 32'h7FFF_FFFF));
    request_backlog.push_back(load_req(2, 4, 32'h8000_0000));
    request_backlog.push_back(eval_req('0));
    request_backlog.push_back(eval_req(TIME_W'(1 << FRAC_BITS)));
    request_backlog.push_back(eval_req('1));
    // rounding tie at half a unit and the smallest nonzero time
    request_backlog.push_back(eval_req(TIME_W'(1 << (FRAC_BITS - 1))));
    request_backlog.push_back(eval_req(TIME_W'(1)));
    // loads to a missing axis or slot must leave the store untouched
    request_backlog.push_back(load_req(3, 0, 32'h5555_5555));
    request_backlog.push_back(load_req(0, 6, 32'h5555_5555));
    request_backlog.push_back(load_req(0, 7, 32'hAAAA_AAAA));
    request_backlog.push_back(eval_req(TIME_W'(1 << FRAC_BITS)));
    // modest profile on x, evaluated with every ignored field set
    for (i = 0; i < COEFS; i++) request_backlog.push_back(load_req(0, i, (i + 1) << 12));
    request_backlog.push_back('{mode: MODE_EVAL, axis_select: '1, coef_slot: '1,
                                coef_word: '1, elapsed_time: 24'h00_C000});

    // segments: a batch of coefficient loads, then a few evaluations
    n = 0;
    while (n < 135) begin
      repeat ($urandom_range(2, 8)) begin
        request_backlog.push_back(load_req(
          ($urandom_range(99) < 95) ? $urandom_range(0, NUM_AXES - 1) : 3,
          ($urandom_range(99) < 92) ? $urandom_range(0, COEFS - 1) : $urandom_range(6, 7),
          random_coef()));
        n++;
      end
      repeat ($urandom_range(1, 4)) begin
        request_backlog.push_back(eval_req(random_time()));
        n++;
      end
    end
    planned = request_backlog.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (accepted < planned || due_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests taken: %0d coefficient loads, %0d evaluations", accepted,
             loads_sent, evals_sent);
    $display("%0d axis results checked, %0d mismatches", samples_checked, errors);
    if (errors == 0 && due_samples.size() == 0) begin
      $display("PASS quintic_trajectory_evaluator");
    end else begin
      $display("FAIL quintic_trajectory_evaluator");
    end
    $finish;
  end

endmodule
